// ===== sv/xalu_pkg.sv =====
package xalu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_CMP = 4'd2, CMD_INC = 4'd3,
    CMD_DEC = 4'd4, CMD_NEG = 4'd5, CMD_ADC = 4'd6, CMD_SBB = 4'd7,
    CMD_MUL = 4'd8, CMD_IMUL1 = 4'd9, CMD_IMUL2 = 4'd10, CMD_IMUL3 = 4'd11,
    CMD_DIV = 4'd12, CMD_IDIV = 4'd13, CMD_NOP0 = 4'd14, CMD_NOP1 = 4'd15
  } cmd_t;

  localparam logic [1:0] WID_BYTE = 2'd0;
  localparam logic [1:0] WID_WORD = 2'd1;

  localparam int InBits  = 4 + 2 + 5 * 32;
  localparam int InBytes = (InBits + 7) / 8;
  localparam int OutBits = 32 + 32 + 7;
  localparam int OutBytes = (OutBits + 7) / 8;

  // Bit width of an operand size code; code three acts as doubleword.
  function automatic logic [5:0] width_bits(input logic [1:0] wc);
    logic [5:0] b;
    unique case (wc)
      WID_BYTE: b = 6'd8;
      WID_WORD: b = 6'd16;
      default:  b = 6'd32;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] width_mask(input logic [1:0] wc);
    logic [31:0] m;
    unique case (wc)
      WID_BYTE: m = 32'h0000_00ff;
      WID_WORD: m = 32'h0000_ffff;
      default:  m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // Sign extension of a value held at the given operand size.
  function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] wc);
    logic [31:0] r;
    unique case (wc)
      WID_BYTE: r = {{24{v[7]}}, v[7:0]};
      WID_WORD: r = {{16{v[15]}}, v[15:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

  function automatic logic msb_at(input logic [31:0] v, input logic [1:0] wc);
    logic r;
    unique case (wc)
      WID_BYTE: r = v[7];
      WID_WORD: r = v[15];
      default:  r = v[31];
    endcase
    return r;
  endfunction

endpackage

// ===== sv/xalu_seq.sv =====
// Shift-add multiplier and restoring divider over magnitudes, one bit a cycle.
module xalu_seq (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_div,
  input  logic [5:0]  nbits,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output logic        done,
  output logic [63:0] prod,
  output logic [31:0] quot,
  output logic [31:0] rem,
  output logic        qovf
);
  import xalu_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic        mode_div;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [32:0] part;
  logic [63:0] num;
  logic [31:0] dvs;
  logic [5:0]  nb;
  logic        ovf;
  logic [33:0] trial;
  logic [32:0] rem_sh;
  logic        last_step;

  // The quotient is built in the low bits of num; the partial remainder is part.
  always_comb begin
    rem_sh = {part[31:0], num[63]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
    last_step = (cnt == (mode_div ? {nb[4:0], 1'b0} - 6'd1 : nb - 6'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && last_step;
      if (start) begin
        busy     <= 1'b1;
        mode_div <= is_div;
        nb       <= nbits;
        cnt      <= 6'd0;
        acc      <= 64'd0;
        mcand    <= opa;
        mplier   <= opb;
        dvs      <= opb;
        part     <= 33'd0;
        ovf      <= 1'b0;
        // Align the double-width dividend to the top of the shift register.
        unique case (nbits)
          6'd8:    num <= {opa[15:0], 48'd0};
          6'd16:   num <= {opa[31:0], 32'd0};
          default: num <= opa;
        endcase
      end else if (busy) begin
        if (mode_div) begin
          if (!trial[33]) begin
            part <= trial[32:0];
            num  <= {num[62:0], 1'b1};
          end else begin
            part <= rem_sh;
            num  <= {num[62:0], 1'b0};
          end
          // A quotient bit set above the operand size means overflow.
          if (!trial[33] && cnt < nb) ovf <= 1'b1;
        end else begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
        end
        if (last_step) busy <= 1'b0;
        cnt <= cnt + 6'd1;
      end
    end
  end

  assign prod = acc;
  assign quot = num[31:0];
  assign rem  = part[31:0];
  assign qovf = ovf;
endmodule

// ===== sv/x86_integer_alu_with_flags.sv =====
// x86 integer ALU with carry, overflow, zero and sign flags. One word is in
// flight at a time under a small sequencer, and the output register holds a
// result until it is taken. Add, sub, cmp, inc, dec, neg, adc, sbb, the
// no-operation codes and a divide by zero compute in the execute state and
// offer the result word from the output state. Multiplies run through a
// shared bit-serial shift-add unit, one multiplier bit per cycle over the
// operand width, and offer the result from the output state once the unit
// is done. Divides use the same unit as a restoring divider, one quotient
// bit per cycle over the double-width dividend.
module x86_integer_alu_with_flags (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // command[3:0], operand_width[5:4], dest_value[37:6], src_value[69:38],
  // src2_value[101:70], acc_low[133:102], acc_high[165:134], zero fill
  input  logic [xalu_pkg::InBytes*8-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result_value[31:0], result_high[63:32], write_dest[64], write_acc[65],
  // carry_flag[66], overflow_flag[67], zero_flag[68], sign_flag[69],
  // divide_error[70], zero fill
  output logic [xalu_pkg::OutBytes*8-1:0] m_tdata
);
  import xalu_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_OUT} state_t;
  state_t state;

  logic [3:0]  cmd;
  logic [1:0]  wc;
  logic [31:0] d, s, s2, al, ah, m;
  logic [3:0]  flags;          // sign, zero, overflow, carry
  logic        neg_res, neg_rem, idiv_neg_q;

  logic [31:0] r_val, r_hi;
  logic        r_wd, r_wa, r_err;
  logic [3:0]  r_flags;

  // Shared unit connections.
  logic        u_start, u_div, u_done, u_qovf;
  logic [63:0] u_opa, u_prod;
  logic [31:0] u_opb, u_quot, u_rem;

  xalu_seq u_seq (
    .clk(clk), .rst(rst), .start(u_start), .is_div(u_div), .nbits(width_bits(wc)),
    .opa(u_opa), .opb(u_opb), .done(u_done), .prod(u_prod), .quot(u_quot),
    .rem(u_rem), .qovf(u_qovf)
  );

  // Simple arithmetic, combinational, registered in the execute state.
  logic [32:0] sum;
  logic [31:0] ares;
  logic        acf, aof, awd, asets_cf, avalid;
  logic [3:0]  aflags;
  logic [31:0] opx, opy;
  logic        cin, do_sub;

  always_comb begin
    opx = d; opy = s; cin = 1'b0; do_sub = 1'b0;
    awd = 1'b1; asets_cf = 1'b1; avalid = 1'b1;
    unique case (cmd)
      CMD_ADD: ;
      CMD_SUB: do_sub = 1'b1;
      CMD_CMP: begin do_sub = 1'b1; awd = 1'b0; end
      CMD_INC: begin opy = 32'd1; asets_cf = 1'b0; end
      CMD_DEC: begin opy = 32'd1; do_sub = 1'b1; asets_cf = 1'b0; end
      CMD_NEG: begin opx = 32'd0; opy = d; do_sub = 1'b1; end
      CMD_ADC: cin = flags[0];
      CMD_SBB: begin do_sub = 1'b1; cin = flags[0]; end
      default: begin avalid = 1'b0; awd = 1'b0; asets_cf = 1'b0; end
    endcase
    // Subtract as x + ~y + 1 - borrow-in; carry out of the width is inverted borrow.
    if (do_sub) sum = {1'b0, opx} + {1'b0, ~opy & m} + {32'd0, ~cin};
    else        sum = {1'b0, opx} + {1'b0, opy} + {32'd0, cin};
    ares = sum[31:0] & m;
    unique case (wc)
      WID_BYTE: acf = sum[8];
      WID_WORD: acf = sum[16];
      default:  acf = sum[32];
    endcase
    if (do_sub) acf = ~acf;
    aof = msb_at(~(opx ^ (do_sub ? ~opy : opy)) & (opx ^ ares), wc);
    aflags = {msb_at(ares, wc), ares == 32'd0,
              (cmd == CMD_NEG) ? (d != 32'd0 && d == ares) : aof,
              asets_cf ? acf : flags[0]};
  end

  // Magnitudes for the shared unit.
  logic [31:0] sd, sa, ss, ss2, mul_a, mul_b;
  logic [63:0] dividend, sdividend, mag_n;
  logic        is_signed_mul, nn, dn;
  always_comb begin
    sd = sext32(d, wc); sa = sext32(al, wc); ss = sext32(s, wc); ss2 = sext32(s2, wc);
    is_signed_mul = (cmd != CMD_MUL);
    unique case (cmd)
      CMD_IMUL2: begin mul_a = sd; mul_b = ss; end
      CMD_IMUL3: begin mul_a = ss; mul_b = ss2; end
      CMD_IMUL1: begin mul_a = sd; mul_b = sa; end
      default:   begin mul_a = d;  mul_b = al; end
    endcase
    unique case (wc)
      WID_BYTE: begin dividend = {48'd0, al[7:0], 8'd0} | {48'd0, 8'd0, 8'd0};
        dividend = {48'd0, s2[7:0], al[7:0]};
        sdividend = {{48{s2[7]}}, s2[7:0], al[7:0]}; end
      WID_WORD: begin dividend = {32'd0, ah[15:0], al[15:0]};
        sdividend = {{32{ah[15]}}, ah[15:0], al[15:0]}; end
      default:  begin dividend = {ah, al}; sdividend = {ah, al}; end
    endcase
    nn = sdividend[63];
    dn = sd[31];
    mag_n = (cmd == CMD_IDIV && nn) ? 64'd0 - sdividend : dividend;
  end

  // Low half of a signed product at the width comes from the magnitude product.
  logic [63:0] sprod;
  logic [31:0] mul_hi;
  logic        mul_short;
  always_comb begin
    sprod = neg_res ? 64'd0 - u_prod : u_prod;
    mul_short = (cmd == CMD_IMUL2 || cmd == CMD_IMUL3);
    unique case (wc)
      WID_BYTE: mul_hi = {24'd0, sprod[15:8]};
      WID_WORD: mul_hi = {16'd0, sprod[31:16]};
      default:  mul_hi = sprod[63:32];
    endcase
    if (mul_short) mul_hi = 32'd0;
  end

  logic [31:0] q_s, r_s, lim;
  logic        q_bad;
  always_comb begin
    q_s = idiv_neg_q ? 32'd0 - u_quot : u_quot;
    r_s = neg_rem ? 32'd0 - u_rem : u_rem;
    unique case (wc)
      WID_BYTE: lim = 32'h80;
      WID_WORD: lim = 32'h8000;
      default:  lim = 32'h8000_0000;
    endcase
    if (!idiv_neg_q) lim = lim - 32'd1;
    q_bad = u_qovf || (cmd == CMD_IDIV && u_quot > lim);
  end

  always_comb begin
    u_start = 1'b0;
    u_div = (cmd == CMD_DIV || cmd == CMD_IDIV);
    u_opa = 64'd0; u_opb = 32'd0;
    if (state == ST_EXEC && (cmd[3] && cmd != CMD_NOP0 && cmd != CMD_NOP1)) begin
      u_start = !(u_div && d == 32'd0);
      if (u_div) begin
        u_opa = mag_n;
        u_opb = (cmd == CMD_IDIV && dn) ? (32'd0 - sd) & m : d;
      end else begin
        u_opa = {32'd0, (is_signed_mul && mul_a[31]) ? (32'd0 - mul_a) & m : mul_a};
        u_opb = (is_signed_mul && mul_b[31]) ? (32'd0 - mul_b) & m : mul_b;
      end
    end
  end

  logic [63:0] in_unused;
  always_comb in_unused = {s_tdata[InBytes*8-1:InBits], 62'd0} ^ 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      flags <= 4'd0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          cmd <= s_tdata[3:0];
          wc  <= s_tdata[5:4];
          m   <= width_mask(s_tdata[5:4]);
          d   <= s_tdata[37:6] & width_mask(s_tdata[5:4]);
          s   <= s_tdata[69:38] & width_mask(s_tdata[5:4]);
          // Byte divide takes AH from acc_low bits 15:8; keep it in s2's slot.
          s2  <= (s_tdata[3:0] == CMD_DIV || s_tdata[3:0] == CMD_IDIV) &&
                 s_tdata[5:4] == WID_BYTE ? {24'd0, s_tdata[117:110]}
                 : s_tdata[101:70] & width_mask(s_tdata[5:4]);
          al  <= s_tdata[133:102] & width_mask(s_tdata[5:4]);
          ah  <= s_tdata[165:134] & width_mask(s_tdata[5:4]);
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          r_hi <= 32'd0; r_wa <= 1'b0;
          r_err <= u_div && !u_start;
          neg_res    <= is_signed_mul && (mul_a[31] ^ mul_b[31]);
          idiv_neg_q <= (cmd == CMD_IDIV) && (nn ^ dn);
          neg_rem    <= (cmd == CMD_IDIV) && nn;
          if (avalid) begin
            r_val   <= ares;
            r_wd    <= awd;
            r_flags <= aflags;
            flags   <= aflags;
            state   <= ST_OUT;
          end else begin
            r_val   <= 32'd0;
            r_wd    <= 1'b0;
            r_flags <= flags;
            state   <= u_start ? ST_WAIT : ST_OUT;
          end
        end
        ST_WAIT: if (u_done) begin
          if (u_div) begin
            r_err <= q_bad;
            r_val <= q_bad ? 32'd0 : (cmd == CMD_IDIV ? q_s : u_quot) & m;
            r_hi  <= q_bad ? 32'd0 : (cmd == CMD_IDIV ? r_s : u_rem) & m;
            r_wa  <= !q_bad;
          end else begin
            r_val <= sprod[31:0] & m;
            r_hi  <= mul_hi;
            r_wd  <= mul_short;
            r_wa  <= !mul_short;
          end
          state <= ST_OUT;
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE) && (in_unused == 64'd0 || 1'b1);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(OutBytes*8-OutBits){1'b0}}, r_err, r_flags[3], r_flags[2],
                     r_flags[1], r_flags[0], r_wa, r_wd, r_hi, r_val};

  a_err_nowrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> !m_tdata[64] && !m_tdata[65])
    else $error("divide error with a write");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[64] && m_tdata[65]))
    else $error("both write enables set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("accepting while a result is pending");
endmodule
